>>> rtl/core/tsc_pkg.sv
// Shared types and constants for the three-sphere trilateration core.
`timescale 1ns / 1ps
package tsc_pkg;

  localparam int RA_W      = 31;  // radius width
  localparam int CRD_W     = 32;  // coordinate width
  localparam int SQ_W      = 63;  // width of a squared magnitude
  localparam int DIV_N_W   = 66;  // dividend width of the divide chains
  localparam int DIV_D_W   = 33;  // divisor width (twice a 32-bit magnitude)
  localparam int DIV_STEPS = DIV_N_W;
  localparam int SQRT_V_W  = 62;  // radicand width
  localparam int SQRT_STEPS = SQRT_V_W / 2;
  localparam int SQRT_REM_W = 33;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CIRCLE = 2'd1,
    ST_ZNEG   = 2'd2,
    ST_DEGEN  = 2'd3
  } fix_status_t;

  // Per-transaction context that travels with the arithmetic.
  typedef struct packed {
    logic [RA_W-1:0]     ra;
    logic [SQ_W-1:0]     ra_sq;
    logic [CRD_W-1:0]    ia;
    logic                i_neg;
    logic [CRD_W-1:0]    j;
    logic [SQ_W-1:0]     rc_sq;
    logic [DIV_N_W-1:0]  pos_base;
    logic                num_neg;
    logic [RA_W-1:0]     x_mag;
    logic                x_neg;
    logic [2*RA_W-1:0]   x_sq;
    logic                negy;
    logic [RA_W-1:0]     y_mag;
    logic                y_neg;
    fix_status_t         st;
  } item_t;

  typedef struct packed {
    logic [DIV_N_W-1:0] n;
    logic [DIV_D_W-1:0] dv;
    logic [DIV_D_W-1:0] rem;
    logic [DIV_N_W-1:0] q;
    item_t              item;
  } div_stage_t;

  typedef struct packed {
    logic [SQRT_V_W-1:0]   v;
    logic [SQRT_REM_W-1:0] rem;
    logic [RA_W-1:0]       root;
    item_t                 item;
  } sqrt_stage_t;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [RA_W-1:0]  z;
    fix_status_t      st;
  } out_item_t;

endpackage

>>> rtl/core/three_sphere_trilateration_core.sv
// Top level of the three-sphere trilateration core.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------------
//  in_     | input     | in_valid / in_ready   | radius_a, centre_b_x, radius_b,
//          |           |                       | centre_c_x, centre_c_y, radius_c
//  out_    | output    | out_valid / out_ready | point_x, point_y, point_z, fix_status
//
// The core accepts one transaction per clock cycle while in_ready is high and returns
// one result per transaction. It holds two 66-cell divide chains and a 31-cell sqrt chain.
// Reset (rst_n low at a clock edge) empties the pipeline and the result buffer.
// A two-entry result buffer keeps accepting while a result waits; in_ready drops only
// when both buffer entries are occupied, and then the whole pipeline holds.
module three_sphere_trilateration_core import tsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RA_W-1:0]         in_radius_a,
  input  logic signed [CRD_W-1:0] in_centre_b_x,
  input  logic [RA_W-1:0]         in_radius_b,
  input  logic signed [CRD_W-1:0] in_centre_c_x,
  input  logic signed [CRD_W-1:0] in_centre_c_y,
  input  logic [RA_W-1:0]         in_radius_c,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CRD_W-1:0] out_point_x,
  output logic signed [CRD_W-1:0] out_point_y,
  output logic [RA_W-1:0]         out_point_z,
  output logic [1:0]              out_fix_status
);

  // The whole pipeline advances together whenever the result buffer has room.
  logic en;
  logic full;

  assign en       = !full;
  assign in_ready = en;

  // Stage 0: capture the transaction.
  logic             p0_vld_r;
  logic [RA_W-1:0]  p0_ra_r, p0_rb_r, p0_rc_r;
  logic [CRD_W-1:0] p0_bx_r, p0_cx_r, p0_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (en) begin
      p0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_ra_r <= in_radius_a;
      p0_rb_r <= in_radius_b;
      p0_rc_r <= in_radius_c;
      p0_bx_r <= in_centre_b_x;
      p0_cx_r <= in_centre_c_x;
      p0_cy_r <= in_centre_c_y;
    end
  end

  // Stage 1: fold into the canonical frame and run the early checks.
  // The order of the checks matters: a zero d wins over the circle test, which
  // in turn wins over a zero j.
  logic              bx_neg, cx_neg;
  logic [CRD_W-1:0]  d_c, cx_mag_c, j_c;
  logic signed [CRD_W+1:0] d_minus_ra;
  logic [CRD_W:0]    d_plus_ra;
  logic              circ_fail;
  item_t             it1_nxt, it1_r;
  logic              p1_vld_r;
  logic [RA_W-1:0]   p1_rb_r, p1_rc_r;
  logic [CRD_W-1:0]  p1_d_r;

  always_comb begin
    bx_neg     = p0_bx_r[CRD_W-1];
    cx_neg     = p0_cx_r[CRD_W-1];
    d_c        = bx_neg ? (~p0_bx_r + 1'b1) : p0_bx_r;
    cx_mag_c   = cx_neg ? (~p0_cx_r + 1'b1) : p0_cx_r;
    j_c        = p0_cy_r[CRD_W-1] ? (~p0_cy_r + 1'b1) : p0_cy_r;
    d_minus_ra = $signed({2'b00, d_c}) - $signed({3'b000, p0_ra_r});
    d_plus_ra  = {1'b0, d_c} + {2'b00, p0_ra_r};
    circ_fail  = (d_minus_ra >= $signed({3'b000, p0_rb_r})) ||
                 ({2'b00, p0_rb_r} >= d_plus_ra);
    it1_nxt       = '0;
    it1_nxt.ra    = p0_ra_r;
    it1_nxt.ia    = cx_mag_c;
    it1_nxt.i_neg = (cx_neg ^ bx_neg) && (cx_mag_c != '0);
    it1_nxt.j     = j_c;
    if (d_c == '0) begin
      it1_nxt.st = ST_DEGEN;
    end else if (circ_fail) begin
      it1_nxt.st = ST_CIRCLE;
    end else if (j_c == '0) begin
      it1_nxt.st = ST_DEGEN;
    end else begin
      it1_nxt.st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= p0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r   <= it1_nxt;
      p1_rb_r <= p0_rb_r;
      p1_rc_r <= p0_rc_r;
      p1_d_r  <= d_c;
    end
  end

  // Stage 2: the six squares, each on its own multiplier.
  logic [2*CRD_W-1:0] ra_sq_c, rb_sq_c, rc_sq_c, d_sq_c, ia_sq_c, j_sq_c;
  item_t              it2_nxt, it2_r;
  logic               p2_vld_r;
  logic [SQ_W-1:0]    p2_rb_sq_r, p2_d_sq_r, p2_ia_sq_r, p2_j_sq_r;
  logic [CRD_W-1:0]   p2_d_r;

  always_comb begin
    ra_sq_c = {{CRD_W{1'b0}}, {(CRD_W-RA_W){1'b0}}, it1_r.ra} * {{(CRD_W-RA_W){1'b0}}, it1_r.ra};
    rb_sq_c = {{CRD_W{1'b0}}, {(CRD_W-RA_W){1'b0}}, p1_rb_r} * {{(CRD_W-RA_W){1'b0}}, p1_rb_r};
    rc_sq_c = {{CRD_W{1'b0}}, {(CRD_W-RA_W){1'b0}}, p1_rc_r} * {{(CRD_W-RA_W){1'b0}}, p1_rc_r};
    d_sq_c  = {{CRD_W{1'b0}}, p1_d_r} * p1_d_r;
    ia_sq_c = {{CRD_W{1'b0}}, it1_r.ia} * it1_r.ia;
    j_sq_c  = {{CRD_W{1'b0}}, it1_r.j} * it1_r.j;
    it2_nxt       = it1_r;
    it2_nxt.ra_sq = ra_sq_c[SQ_W-1:0];
    it2_nxt.rc_sq = rc_sq_c[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it2_r      <= it2_nxt;
      p2_rb_sq_r <= rb_sq_c[SQ_W-1:0];
      p2_d_sq_r  <= d_sq_c[SQ_W-1:0];
      p2_ia_sq_r <= ia_sq_c[SQ_W-1:0];
      p2_j_sq_r  <= j_sq_c[SQ_W-1:0];
      p2_d_r     <= p1_d_r;
    end
  end

  // Stage 3: numerator of x and the constant part of the y numerator.
  item_t              it3_nxt, it3_r;
  logic               p3_vld_r;
  logic [2*CRD_W-1:0] p3_num_r;
  logic [CRD_W-1:0]   p3_d_r;

  always_comb begin
    it3_nxt          = it2_r;
    it3_nxt.pos_base = {3'b000, it2_r.ra_sq} + {3'b000, p2_ia_sq_r} + {3'b000, p2_j_sq_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it3_r    <= it3_nxt;
      p3_num_r <= {1'b0, it2_r.ra_sq} + {1'b0, p2_d_sq_r} - {1'b0, p2_rb_sq_r};
      p3_d_r   <= p2_d_r;
    end
  end

  // Divide chain for x = num / (2d), on magnitudes.
  logic               dx_vld [DIV_STEPS+1];
  div_stage_t         dx_stg [DIV_STEPS+1];
  logic [2*CRD_W-1:0] num_mag_c;

  always_comb begin
    num_mag_c              = p3_num_r[2*CRD_W-1] ? (~p3_num_r + 1'b1) : p3_num_r;
    dx_vld[0]              = p3_vld_r;
    dx_stg[0].n            = {{(DIV_N_W-SQ_W){1'b0}}, num_mag_c[SQ_W-1:0]};
    dx_stg[0].dv           = {p3_d_r, 1'b0};
    dx_stg[0].rem          = '0;
    dx_stg[0].q            = '0;
    dx_stg[0].item         = it3_r;
    dx_stg[0].item.num_neg = p3_num_r[2*CRD_W-1];
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_x
    tsc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (dx_vld[k]),
      .in_stg  (dx_stg[k]),
      .out_vld (dx_vld[k+1]),
      .out_stg (dx_stg[k+1])
    );
  end

  // Stage 4: x magnitude check. A quotient above ra means z squared is negative.
  item_t it4_nxt, it4_r;
  logic  p4_vld_r;

  always_comb begin
    it4_nxt       = dx_stg[DIV_STEPS].item;
    it4_nxt.x_mag = dx_stg[DIV_STEPS].q[RA_W-1:0];
    it4_nxt.x_neg = dx_stg[DIV_STEPS].item.num_neg &&
                    (dx_stg[DIV_STEPS].q[RA_W-1:0] != '0);
    if ((it4_nxt.st == ST_OK) &&
        (dx_stg[DIV_STEPS].q > {{(DIV_N_W-RA_W){1'b0}}, it4_nxt.ra})) begin
      it4_nxt.st = ST_ZNEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else if (en) begin
      p4_vld_r <= dx_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it4_r <= it4_nxt;
    end
  end

  // Stage 5: |i|*|x| and x squared.
  item_t              it5_nxt, it5_r;
  logic               p5_vld_r;
  logic [2*CRD_W-1:0] ixa_c, x_sq_c;
  logic [SQ_W-1:0]    p5_ixa_r;

  always_comb begin
    ixa_c        = {{CRD_W{1'b0}}, it4_r.ia} * {{(CRD_W-RA_W){1'b0}}, it4_r.x_mag};
    x_sq_c       = {{CRD_W{1'b0}}, {(CRD_W-RA_W){1'b0}}, it4_r.x_mag} *
                   {{(CRD_W-RA_W){1'b0}}, it4_r.x_mag};
    it5_nxt      = it4_r;
    it5_nxt.x_sq = x_sq_c[2*RA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else if (en) begin
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it5_r    <= it5_nxt;
      p5_ixa_r <= ixa_c[SQ_W-1:0];
    end
  end

  // Stage 6: split the y numerator into its positive and negative sums.
  // The 2*i*x term joins the positive side when i and x have opposite signs.
  item_t              it6_r;
  logic               p6_vld_r;
  logic [DIV_N_W-1:0] two_ix_c;
  logic               opp_c;
  logic [DIV_N_W-1:0] p6_pos_r, p6_neg_r;

  always_comb begin
    two_ix_c = {{(DIV_N_W-SQ_W-1){1'b0}}, p5_ixa_r, 1'b0};
    opp_c    = it5_r.i_neg != it5_r.x_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
    end else if (en) begin
      p6_vld_r <= p5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it6_r    <= it5_r;
      p6_pos_r <= it5_r.pos_base + (opp_c ? two_ix_c : '0);
      p6_neg_r <= {{(DIV_N_W-SQ_W){1'b0}}, it5_r.rc_sq} + (opp_c ? '0 : two_ix_c);
    end
  end

  // Stage 7: magnitude and sign of the y numerator.
  item_t              it7_nxt, it7_r;
  logic               p7_vld_r;
  logic               negy_c;
  logic [DIV_N_W-1:0] p7_m_r;

  always_comb begin
    negy_c       = p6_pos_r < p6_neg_r;
    it7_nxt      = it6_r;
    it7_nxt.negy = negy_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_vld_r <= 1'b0;
    end else if (en) begin
      p7_vld_r <= p6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it7_r  <= it7_nxt;
      p7_m_r <= negy_c ? (p6_neg_r - p6_pos_r) : (p6_pos_r - p6_neg_r);
    end
  end

  // Divide chain for y = m / (2j).
  logic       dy_vld [DIV_STEPS+1];
  div_stage_t dy_stg [DIV_STEPS+1];

  always_comb begin
    dy_vld[0]      = p7_vld_r;
    dy_stg[0].n    = p7_m_r;
    dy_stg[0].dv   = {it7_r.j, 1'b0};
    dy_stg[0].rem  = '0;
    dy_stg[0].q    = '0;
    dy_stg[0].item = it7_r;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_y
    tsc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (dy_vld[k]),
      .in_stg  (dy_stg[k]),
      .out_vld (dy_vld[k+1]),
      .out_stg (dy_stg[k+1])
    );
  end

  // Stage 8: y magnitude check.
  item_t it8_nxt, it8_r;
  logic  p8_vld_r;

  always_comb begin
    it8_nxt       = dy_stg[DIV_STEPS].item;
    it8_nxt.y_mag = dy_stg[DIV_STEPS].q[RA_W-1:0];
    it8_nxt.y_neg = dy_stg[DIV_STEPS].item.negy &&
                    (dy_stg[DIV_STEPS].q[RA_W-1:0] != '0);
    if ((it8_nxt.st == ST_OK) &&
        (dy_stg[DIV_STEPS].q > {{(DIV_N_W-RA_W){1'b0}}, it8_nxt.ra})) begin
      it8_nxt.st = ST_ZNEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p8_vld_r <= 1'b0;
    end else if (en) begin
      p8_vld_r <= dy_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it8_r <= it8_nxt;
    end
  end

  // Stage 9: y squared.
  item_t              it9_r;
  logic               p9_vld_r;
  logic [2*CRD_W-1:0] y_sq_c;
  logic [2*RA_W-1:0]  p9_y_sq_r;

  assign y_sq_c = {{CRD_W{1'b0}}, {(CRD_W-RA_W){1'b0}}, it8_r.y_mag} *
                  {{(CRD_W-RA_W){1'b0}}, it8_r.y_mag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p9_vld_r <= 1'b0;
    end else if (en) begin
      p9_vld_r <= p8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it9_r     <= it8_r;
      p9_y_sq_r <= y_sq_c[2*RA_W-1:0];
    end
  end

  // Stage 10: z squared and its sign check.
  item_t               it10_nxt, it10_r;
  logic                p10_vld_r;
  logic [2*CRD_W-1:0]  z_sq_c;
  logic [SQRT_V_W-1:0] p10_v_r;

  always_comb begin
    z_sq_c   = {1'b0, it9_r.ra_sq} - {2'b00, it9_r.x_sq} - {2'b00, p9_y_sq_r};
    it10_nxt = it9_r;
    if ((it10_nxt.st == ST_OK) && z_sq_c[2*CRD_W-1]) begin
      it10_nxt.st = ST_ZNEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p10_vld_r <= 1'b0;
    end else if (en) begin
      p10_vld_r <= p9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it10_r  <= it10_nxt;
      p10_v_r <= z_sq_c[SQRT_V_W-1:0];
    end
  end

  // Square root chain, one root bit per cell.
  logic        sq_vld [SQRT_STEPS+1];
  sqrt_stage_t sq_stg [SQRT_STEPS+1];

  always_comb begin
    sq_vld[0]      = p10_vld_r;
    sq_stg[0].v    = p10_v_r;
    sq_stg[0].rem  = '0;
    sq_stg[0].root = '0;
    sq_stg[0].item = it10_r;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    tsc_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (sq_vld[k]),
      .in_stg  (sq_stg[k]),
      .out_vld (sq_vld[k+1]),
      .out_stg (sq_stg[k+1])
    );
  end

  // Result assembly: a failed fix reports zero coordinates.
  item_t     it_fin;
  out_item_t res_c;
  out_item_t res_out;
  logic      push;

  always_comb begin
    it_fin = sq_stg[SQRT_STEPS].item;
    res_c  = '0;
    res_c.st = it_fin.st;
    if (it_fin.st == ST_OK) begin
      res_c.x = it_fin.x_neg ? (~{1'b0, it_fin.x_mag} + 1'b1) : {1'b0, it_fin.x_mag};
      res_c.y = it_fin.y_neg ? (~{1'b0, it_fin.y_mag} + 1'b1) : {1'b0, it_fin.y_mag};
      res_c.z = sq_stg[SQRT_STEPS].root;
    end
  end

  assign push = sq_vld[SQRT_STEPS] && en;

  tsc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res_c),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (res_out),
    .full      (full)
  );

  assign out_point_x    = res_out.x;
  assign out_point_y    = res_out.y;
  assign out_point_z    = res_out.z;
  assign out_fix_status = res_out.st;

endmodule

>>> rtl/core/tsc_div_cell.sv
// Restoring-division cell: one quotient bit per enabled cycle.
`timescale 1ns / 1ps
module tsc_div_cell import tsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  div_stage_t in_stg,
  output logic       out_vld,
  output div_stage_t out_stg
);

  logic             vld_r;
  div_stage_t       stg_r;
  div_stage_t       stg_nxt;
  logic [DIV_D_W:0] r2;
  logic [DIV_D_W:0] diff;
  logic             ge;

  always_comb begin
    r2   = {in_stg.rem, in_stg.n[DIV_N_W-1]};
    ge   = r2 >= {1'b0, in_stg.dv};
    diff = r2 - {1'b0, in_stg.dv};
    stg_nxt      = in_stg;
    stg_nxt.rem  = ge ? diff[DIV_D_W-1:0] : r2[DIV_D_W-1:0];
    stg_nxt.n    = {in_stg.n[DIV_N_W-2:0], 1'b0};
    stg_nxt.q    = {in_stg.q[DIV_N_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_stg = stg_r;

endmodule

>>> rtl/core/tsc_sqrt_cell.sv
// Digit-by-digit square root cell: one root bit per enabled cycle.
`timescale 1ns / 1ps
module tsc_sqrt_cell import tsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  sqrt_stage_t in_stg,
  output logic        out_vld,
  output sqrt_stage_t out_stg
);

  logic                  vld_r;
  sqrt_stage_t           stg_r;
  sqrt_stage_t           stg_nxt;
  logic [SQRT_REM_W+1:0] r4;
  logic [SQRT_REM_W+1:0] trial;
  logic [SQRT_REM_W+1:0] diff;
  logic                  ge;

  always_comb begin
    r4    = {in_stg.rem, in_stg.v[SQRT_V_W-1 -: 2]};
    trial = {{(SQRT_REM_W+2-RA_W-2){1'b0}}, in_stg.root, 2'b01};
    ge    = r4 >= trial;
    diff  = r4 - trial;
    stg_nxt      = in_stg;
    stg_nxt.rem  = ge ? diff[SQRT_REM_W-1:0] : r4[SQRT_REM_W-1:0];
    stg_nxt.root = {in_stg.root[RA_W-2:0], ge};
    stg_nxt.v    = {in_stg.v[SQRT_V_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_stg = stg_r;

endmodule

>>> rtl/core/tsc_out_buf.sv
// Two-entry result buffer between the pipeline and the output channel.
`timescale 1ns / 1ps
module tsc_out_buf import tsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  input  logic      pop_ready,
  output logic      pop_valid,
  output out_item_t pop_data,
  output logic      full
);

  out_item_t  buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign pop_valid = cnt_r != 2'd0;
  assign pop_data  = buf_r[rd_ptr_r];
  assign full      = cnt_r == 2'd2;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/tsc_checker.sv
// Port-level checks for the trilateration core, bound to the top level.
`timescale 1ns / 1ps
module tsc_checker import tsc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [CRD_W-1:0] out_point_x,
  input logic signed [CRD_W-1:0] out_point_y,
  input logic [RA_W-1:0]         out_point_z,
  input logic [1:0]              out_fix_status
);

  // A failed fix carries an all-zero point.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fix_status != ST_OK)) |->
      (out_point_x == '0 && out_point_y == '0 && out_point_z == '0))
    else $error("failed fix with nonzero point");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A refused input never coexists with an empty output side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid) |-> in_ready)
    else $error("input stalled with no result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_point_x) && $stable(out_point_y) &&
       $stable(out_point_z) && $stable(out_fix_status)))
    else $error("result changed while stalled");

endmodule

bind three_sphere_trilateration_core tsc_checker u_tsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_point_x    (out_point_x),
  .out_point_y    (out_point_y),
  .out_point_z    (out_point_z),
  .out_fix_status (out_fix_status)
);

>>> bench/three_sphere_trilateration_core_test.sv
// Self-checking testbench for the three-sphere trilateration core.
`timescale 1ns / 1ps
module three_sphere_trilateration_core_test;
  import tsc_pkg::*;

  localparam int N_RANDOM    = 1650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 300;

  // One set of three spheres as it is presented on the input channel.
  typedef struct {
    logic [RA_W-1:0]         ra;
    logic signed [CRD_W-1:0] bx;
    logic [RA_W-1:0]         rb;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [RA_W-1:0]         rc;
  } spheres_t;

  // One computed intersection point with its status.
  typedef struct {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic [RA_W-1:0]         z;
    fix_status_t             st;
  } fix_t;

  // A row of the directed table; typed rows carry their own expected fix.
  typedef struct {
    spheres_t s;
    bit       typed;
    fix_t     fix;
  } row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [RA_W-1:0]         in_radius_a;
  logic signed [CRD_W-1:0] in_centre_b_x;
  logic [RA_W-1:0]         in_radius_b;
  logic signed [CRD_W-1:0] in_centre_c_x;
  logic signed [CRD_W-1:0] in_centre_c_y;
  logic [RA_W-1:0]         in_radius_c;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [CRD_W-1:0] out_point_x;
  logic signed [CRD_W-1:0] out_point_y;
  logic [RA_W-1:0]         out_point_z;
  logic [1:0]              out_fix_status;

  three_sphere_trilateration_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_radius_a    (in_radius_a),
    .in_centre_b_x  (in_centre_b_x),
    .in_radius_b    (in_radius_b),
    .in_centre_c_x  (in_centre_c_x),
    .in_centre_c_y  (in_centre_c_y),
    .in_radius_c    (in_radius_c),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_fix_status (out_fix_status)
  );

  row_t directed[$];
  fix_t pending_fixes[$];
  int   n_total;
  int   n_sent;
  int   n_errors;
  int   cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of the integer square root, one result bit per step.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Intersection of the three spheres with exact wide arithmetic.
  function automatic fix_t trilaterate(spheres_t s);
    longint ra, bx, rb, cx, cy, rc, d, i, j, ia, xa, x, y, num, z2;
    logic [127:0] pos, neg, m, q, two_ix;
    fix_t f;
    ra = longint'(s.ra);
    rb = longint'(s.rb);
    rc = longint'(s.rc);
    bx = longint'(s.bx);
    cx = longint'(s.cx);
    cy = longint'(s.cy);
    f.x = '0;
    f.y = '0;
    f.z = '0;
    f.st = ST_OK;
    d = bx < 0 ? -bx : bx;
    i = bx < 0 ? -cx : cx;
    j = cy < 0 ? -cy : cy;
    if (d == 0) begin
      f.st = ST_DEGEN;
    end else if ((d - ra >= rb) || (rb >= d + ra)) begin
      f.st = ST_CIRCLE;
    end else if (j == 0) begin
      f.st = ST_DEGEN;
    end else begin
      num = ra * ra - rb * rb + d * d;
      x = num / (2 * d);
      if (x > ra || x < -ra) begin
        f.st = ST_ZNEG;
      end else begin
        ia = i < 0 ? -i : i;
        xa = x < 0 ? -x : x;
        two_ix = 128'(ia * xa) << 1;
        pos = 128'(ra * ra) + 128'(ia * ia) + 128'(j * j);
        neg = 128'(rc * rc);
        if ((i < 0) != (x < 0)) pos = pos + two_ix;
        else neg = neg + two_ix;
        m = (pos < neg) ? neg - pos : pos - neg;
        q = m / 128'(2 * j);
        if (q > 128'(ra)) begin
          f.st = ST_ZNEG;
        end else begin
          y = (pos < neg) ? -longint'(q) : longint'(q);
          z2 = ra * ra - x * x - y * y;
          if (z2 < 0) begin
            f.st = ST_ZNEG;
          end else begin
            f.x = x[CRD_W-1:0];
            f.y = y[CRD_W-1:0];
            f.z = RA_W'(floor_sqrt(longint'(z2)));
          end
        end
      end
    end
    return f;
  endfunction

  // Random spheres: mostly built around a true point, some pure noise.
  function automatic spheres_t random_spheres();
    spheres_t s;
    longint px, py, pz, bx, cx, cy;
    int sc;
    if ($urandom_range(0, 99) < 25) begin
      s.ra = RA_W'($urandom);
      s.bx = $urandom;
      s.rb = RA_W'($urandom);
      s.cx = $urandom;
      s.cy = $urandom;
      s.rc = RA_W'($urandom);
      if ($urandom_range(0, 3) == 0) s.bx = '0;
      if ($urandom_range(0, 3) == 0) s.cy = '0;
    end else begin
      // Most sets use modest coordinates, a few reach far out.
      sc = ($urandom_range(0, 9) == 0) ? 29 : $urandom_range(8, 23);
      px = longint'($signed($urandom)) >>> (32 - sc);
      py = longint'($signed($urandom)) >>> (32 - sc);
      pz = longint'($urandom) >> (32 - sc);
      bx = longint'($signed($urandom)) >>> (32 - sc);
      cx = longint'($signed($urandom)) >>> (32 - sc);
      cy = longint'($signed($urandom)) >>> (32 - sc);
      if (bx == 0) bx = 1;
      s.bx = bx[CRD_W-1:0];
      s.cx = cx[CRD_W-1:0];
      s.cy = cy[CRD_W-1:0];
      s.ra = RA_W'(floor_sqrt(px * px + py * py + pz * pz));
      s.rb = RA_W'(floor_sqrt((px - bx) * (px - bx) + py * py + pz * pz));
      s.rc = RA_W'(floor_sqrt((px - cx) * (px - cx) + (py - cy) * (py - cy) + pz * pz));
      // Nudge a radius now and then to land near the edges of the fix.
      if ($urandom_range(0, 4) == 0) s.rc = s.rc + RA_W'($urandom_range(0, 64));
      if ($urandom_range(0, 9) == 0) s.rb = s.rb - RA_W'($urandom_range(0, 64));
    end
    return s;
  endfunction

  function automatic row_t make_row(spheres_t s, bit typed, fix_status_t st);
    row_t r;
    r.s = s;
    r.typed = typed;
    r.fix.x = '0;
    r.fix.y = '0;
    r.fix.z = '0;
    r.fix.st = st;
    return r;
  endfunction

  function automatic spheres_t sph(longint ra, longint bx, longint rb,
                                   longint cx, longint cy, longint rc);
    spheres_t s;
    s.ra = ra[RA_W-1:0];
    s.bx = bx[CRD_W-1:0];
    s.rb = rb[RA_W-1:0];
    s.cx = cx[CRD_W-1:0];
    s.cy = cy[CRD_W-1:0];
    s.rc = rc[RA_W-1:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    spheres_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        // The transaction just accepted carries what the ports hold now.
        s.ra = in_radius_a;
        s.bx = in_centre_b_x;
        s.rb = in_radius_b;
        s.cx = in_centre_c_x;
        s.cy = in_centre_c_y;
        s.rc = in_radius_c;
        if (n_sent < directed.size() && directed[n_sent].typed)
          pending_fixes.push_back(directed[n_sent].fix);
        else
          pending_fixes.push_back(trilaterate(s));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (n_sent < n_total) begin
          if (n_sent < directed.size()) s = directed[n_sent].s;
          else s = random_spheres();
          in_valid <= 1'b1;
          in_radius_a <= s.ra;
          in_centre_b_x <= s.bx;
          in_radius_b <= s.rb;
          in_centre_c_x <= s.cx;
          in_centre_c_y <= s.cy;
          in_radius_c <= s.rc;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: out_ready stalls at a rate redrawn from 0, 35 or 70 percent.
  int stall_pct;
  always @(posedge clk) begin
    if (cycles % 400 == 0) stall_pct = $urandom_range(0, 2) * 35;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each result transaction with the oldest pending fix.
  always @(posedge clk) begin
    fix_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fixes.size() == 0) begin
        $display("result with no pending fix");
        n_errors++;
      end else begin
        want = pending_fixes.pop_front();
        if (out_point_x !== want.x) report_mismatch("point_x", out_point_x, want.x);
        if (out_point_y !== want.y) report_mismatch("point_y", out_point_y, want.y);
        if (out_point_z !== want.z) report_mismatch("point_z", out_point_z, want.z);
        if (out_fix_status !== want.st)
          report_mismatch("fix_status", out_fix_status, want.st);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_radius_a = '0;
    in_centre_b_x = '0;
    in_radius_b = '0;
    in_centre_c_x = '0;
    in_centre_c_y = '0;
    in_radius_c = '0;
    n_sent = 0;
    n_errors = 0;
    cycles = 0;
    stall_pct = 0;
    // All zero: B sits on A, so the frame is degenerate.
    directed.push_back(make_row(sph(0, 0, 0, 0, 0, 0), 1, ST_DEGEN));
    directed.push_back(make_row(sph(32'h7fffffff, 0, 32'h7fffffff, 5, 5, 5), 1, ST_DEGEN));
    // Spheres A and B too far apart to meet.
    directed.push_back(make_row(sph(1, 10 << 16, 1, 3, 3, 3), 1, ST_CIRCLE));
    // One sphere wholly inside the other.
    directed.push_back(make_row(sph(1 << 16, 1 << 16, 5 << 16, 3, 3, 3), 1, ST_CIRCLE));
    // A and B meet, but C lies on the x axis.
    directed.push_back(make_row(sph(1 << 16, 1 << 16, 1 << 16, 7, 0, 1), 1, ST_DEGEN));
    directed.push_back(make_row(sph(1 << 16, -(1 << 16), 1 << 16, -7, 0, 1), 1, ST_DEGEN));
    // Largest and smallest field values, checked by the predictor.
    directed.push_back(make_row(sph(32'h7fffffff, -64'sd2147483648, 32'h7fffffff,
                                    32'h7fffffff, -64'sd2147483648, 32'h7fffffff), 0, ST_OK));
    directed.push_back(make_row(sph(32'h7fffffff, 32'h7fffffff, 32'h7ffffffe,
                                    -64'sd2147483648, 32'h7fffffff, 0), 0, ST_OK));
    directed.push_back(make_row(sph(32'h7fffffff, 32'h7fffffff, 1,
                                    32'h7fffffff, 32'h7fffffff, 1), 0, ST_OK));
    // Fixes at 1 << 16 scale: one point above the plane and two on it.
    directed.push_back(make_row(sph(2 << 16, 2 << 16, 2 << 16, 1 << 16, 2 << 16, 2 << 16),
                                0, ST_OK));
    directed.push_back(make_row(sph(3 << 16, -(4 << 16), 5 << 16, 0, 3 << 16, 0), 0, ST_OK));
    directed.push_back(make_row(sph(3 << 16, 4 << 16, 5 << 16, -(2 << 16), -(3 << 16), 2 << 16),
                                0, ST_OK));
    // Radius of C too small, so z squared goes negative.
    directed.push_back(make_row(sph(2 << 16, 2 << 16, 2 << 16, 1 << 16, 5 << 16, 1), 0, ST_OK));
    directed.push_back(make_row(sph(1, 1, 1, 1, 1, 1), 0, ST_OK));
    n_total = directed.size() + N_RANDOM;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (n_sent == n_total && pending_fixes.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tsc_pkg.sv
rtl/core/tsc_div_cell.sv
rtl/core/tsc_sqrt_cell.sv
rtl/core/tsc_out_buf.sv
rtl/core/three_sphere_trilateration_core.sv
rtl/core/tsc_checker.sv
bench/three_sphere_trilateration_core_test.sv
